[src/srt_pkg.sv]
// Package: sizes, status codes and shared types for the sorted record table.
package srt_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 32;
    localparam int SCORE_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Input transaction layout
    typedef struct packed {
        logic                     opcode;
        logic signed [KEY_W-1:0]  key;
        logic [SCORE_W-1:0]       score_tenths;
    } srt_req_t;

    // Result transaction layout
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
    } srt_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the incoming transaction
        logic commit;    // apply the shift and update the count
    } srt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic found;
    } srt_stat_t;

endpackage

[src/srt_if.sv]
// Valid/ready channel interface carrying a generic payload.
interface srt_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/srt_datapath.sv]
// Datapath: cell chain of records with parallel compare and one-step shift.
module srt_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srt_pkg::srt_cmd_t             cmd,
    input  logic                          in_op,
    input  logic signed [srt_pkg::KEY_W-1:0]   in_key,
    input  logic [srt_pkg::SCORE_W-1:0]   in_score,
    output srt_pkg::srt_stat_t            stat,
    output logic [srt_pkg::STATUS_W-1:0]  res_status,
    output logic [srt_pkg::POS_W-1:0]     res_position,
    output logic [srt_pkg::COUNT_W-1:0]   res_count
);
    import srt_pkg::*;

    logic signed [KEY_W-1:0]   keys_reg   [CAPACITY];
    logic        [SCORE_W-1:0] scores_reg [CAPACITY];
    logic [CNT_W-1:0]          count_reg;
    logic                      op_reg;
    logic signed [KEY_W-1:0]   key_reg;
    logic [SCORE_W-1:0]        score_reg;

    logic [CAPACITY-1:0] live;
    logic [CAPACITY-1:0] ge_hit;   // live and key >= new key
    logic [CAPACITY-1:0] eq_hit;   // live and key == new key
    logic [CAPACITY-1:0] eq_first; // first matching cell
    logic [CAPACITY-1:0] eq_after; // cells after the first match
    logic [CAPACITY-1:0] ge_at;    // cells at or past insert point
    logic [CAPACITY-1:0] ins_at;   // the insert point itself
    logic [CAPACITY-1:0] ins_shift; // cell takes its lower neighbor on insert
    logic [IDX_W-1:0]    ins_pos;
    logic [IDX_W-1:0]    del_pos;
    logic [STATUS_W-1:0] status_next;
    logic [CNT_W-1:0]    count_next;
    logic [IDX_W-1:0]    pos_next;

    // Per-cell compares; prefix chains mark insert point and first match
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            live[i]   = (CNT_W'(i) < count_reg);
            ge_hit[i] = live[i] && (keys_reg[i] >= key_reg);
            eq_hit[i] = live[i] && (keys_reg[i] == key_reg);
        end
        ge_at[0]     = ge_hit[0] || !live[0];
        ins_at[0]    = ge_at[0];
        ins_shift[0] = 1'b0;
        eq_after[0]  = 1'b0;
        eq_first[0]  = eq_hit[0];
        for (int i = 1; i < CAPACITY; i++)
        begin
            ge_at[i]     = ge_at[i-1] || ge_hit[i] || !live[i];
            ins_at[i]    = ge_at[i] && !ge_at[i-1];
            ins_shift[i] = ge_at[i-1];
            eq_after[i]  = eq_after[i-1] || eq_hit[i-1];
            eq_first[i]  = eq_hit[i] && !eq_after[i];
        end
        ins_pos = '0;
        del_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (ins_at[i])
                ins_pos = IDX_W'(i);
            if (eq_first[i])
                del_pos = IDX_W'(i);
        end
    end

    assign stat.full  = (count_reg == CNT_W'(CAPACITY));
    assign stat.found = |eq_hit;

    // Result selection
    always_comb
    begin
        status_next = ST_FULL;
        count_next  = count_reg;
        pos_next    = '0;
        if (op_reg == OP_INSERT)
        begin
            if (!stat.full)
            begin
                status_next = ST_INSERTED;
                count_next  = count_reg + 1'b1;
                pos_next    = ins_pos;
            end
        end
        else if (stat.found)
        begin
            status_next = ST_DELETED;
            count_next  = count_reg - 1'b1;
            pos_next    = del_pos;
        end
        else
        begin
            status_next = ST_NOT_FOUND;
        end
    end

    // Capture the transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_op;
            key_reg   <= in_key;
            score_reg <= in_score;
        end
    end

    // Cell chain: cells from the insert or delete point move in one step
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (op_reg == OP_INSERT && !stat.full)
                begin
                    if (ins_at[i])
                    begin
                        keys_reg[i]   <= key_reg;
                        scores_reg[i] <= score_reg;
                    end
                    else if (ins_shift[i])
                    begin
                        keys_reg[i]   <= keys_reg[(i+CAPACITY-1) % CAPACITY];
                        scores_reg[i] <= scores_reg[(i+CAPACITY-1) % CAPACITY];
                    end
                end
                else if (op_reg == OP_DELETE && (eq_first[i] || eq_after[i])
                         && i + 1 < CAPACITY)
                begin
                    keys_reg[i]   <= keys_reg[(i+1) % CAPACITY];
                    scores_reg[i] <= scores_reg[(i+1) % CAPACITY];
                end
            end
        end
    end

    // Count and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_status   <= status_next;
            res_position <= POS_W'(pos_next);
            res_count    <= COUNT_W'(count_next);
        end
    end

    ap_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY)) else $error("count above capacity");
    ap_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && op_reg == OP_INSERT && stat.full |=> $stable(count_reg))
        else $error("full insert changed count");
    ap_miss_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && op_reg == OP_DELETE && !stat.found |=> $stable(count_reg))
        else $error("missed delete changed count");
endmodule

[src/srt_ctrl.sv]
// Controller: sequences load, commit and result handshake.
module srt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  srt_pkg::srt_stat_t stat,
    output srt_pkg::srt_cmd_t  cmd
);
    import srt_pkg::*;

    typedef enum logic [1:0] {IDLE, WORK, SHOW} state_t;
    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready   = (state_reg == IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.load   = in_valid && in_ready;
    assign cmd.commit = (state_reg == WORK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                    if (cmd.load)
                        state_reg <= WORK;
                WORK:
                begin
                    state_reg     <= SHOW;
                    out_valid_reg <= 1'b1;
                end
                SHOW:
                    if (out_ready)
                    begin
                        state_reg     <= IDLE;
                        out_valid_reg <= 1'b0;
                    end
                default:
                    state_reg <= IDLE;
            endcase
        end
    end

    ap_valid_show: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid == (state_reg == SHOW)) else $error("valid out of step");
    ap_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !cmd.commit) else $error("double commit");
    ap_load_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.commit) else $error("load without commit");
    ap_stat_known: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !$isunknown(stat)) else $error("status unknown at commit");
endmodule

[src/sorted_record_table.sv]
// Sorted record table: insert/delete into a 64-entry ascending key table.
// Flow: the controller captures the input transaction, commits it in WORK, then
// holds the result in SHOW until taken; result valid is raised on entry to SHOW.
// No new transaction is accepted until the result is taken and the controller
// is back in IDLE.
// Reset: rst_n clears the count and control; cell contents need no reset.
module sorted_record_table (
    input logic clk,
    input logic rst_n,
    srt_if.sink   in_ch,
    srt_if.source out_ch
);
    import srt_pkg::*;

    srt_cmd_t  cmd;
    srt_stat_t stat;

    srt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    srt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_op        (in_ch.data.opcode),
        .in_key       (in_ch.data.key),
        .in_score     (in_ch.data.score_tenths),
        .stat         (stat),
        .res_status   (out_ch.data.status),
        .res_position (out_ch.data.position),
        .res_count    (out_ch.data.entry_count)
    );
endmodule
